>>> hw/rtl/tjb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Timestamp jitter buffer package
// Shared widths, item codes and payload types of the jitter buffer.
// ----------------------------------------------------------------------------
package tjb_pkg;

  localparam int unsigned TimeW        = 63;
  localparam int unsigned TagW         = 16;
  localparam int unsigned PendW        = 7;
  localparam int unsigned WinW         = 32;
  localparam int unsigned DepthDefault = 64;

  localparam logic [1:0] KIND_MEDIA = 2'd0;
  localparam logic [1:0] KIND_CLEAR = 2'd1;

  typedef struct packed {
    logic [1:0]       kind;
    logic [TimeW-1:0] frame_time;
    logic [TagW-1:0]  frame_tag;
  } tjb_in_t;

  typedef struct packed {
    logic             has_frame;
    logic [TagW-1:0]  out_tag;
    logic [TimeW-1:0] out_time;
    logic             accepted;
    logic [PendW-1:0] pending;
    logic [TimeW-1:0] spread;
    logic             last;
  } tjb_res_t;

  typedef struct packed {
    logic [TimeW-1:0] slot_time;
    logic [TagW-1:0]  slot_tag;
  } tjb_entry_t;

endpackage : tjb_pkg
`default_nettype wire

>>> hw/rtl/tjb_slot_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Jitter buffer slot memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tjb_slot_mem
  import tjb_pkg::*;
#(
  parameter int unsigned DEPTH = DepthDefault,
  localparam int unsigned AddrW = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  tjb_entry_t            wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output tjb_entry_t            rdata_o
);

  tjb_entry_t mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule : tjb_slot_mem
`default_nettype wire

>>> hw/rtl/timestamp_jitter_buffer_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Timestamp jitter buffer
// Reorder store for media frames, kept sorted by timestamp in a slot memory.
// ----------------------------------------------------------------------------
// An item is transferred in when start_i is high and busy_o is low. Each result
// appears on res_o for one cycle with res_valid_o high; the receiver cannot
// stall, so it must take every result as it comes. The last result of an item
// has res_o.last set.
// Clear items, refused items, transit frames (window zero) and frames hitting
// a full store give one result in the cycle after the transfer.
// A stored frame walks the sorted ring from its newest entry toward the
// oldest, one entry per cycle through the single memory read port; a frame
// for an empty store is written straight into the head slot. Each release
// then waits for the next oldest entry to be read back from memory, and
// busy_o stays high until the last result.
// The store is a circular buffer: releases only move the head pointer.
// Reset empties the store and sets the window to zero; the memory itself
// is never cleared, as only entries below the fill count are ever used.
// The window register may be written only while the block is idle.
// ----------------------------------------------------------------------------
module timestamp_jitter_buffer_unit
  import tjb_pkg::*;
#(
  parameter int unsigned DEPTH = DepthDefault
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  output logic                   busy_o,
  input  tjb_in_t                in_i,
  input  wire logic              cfg_we_i,
  input  wire logic [WinW-1:0]   cfg_wdata_i,
  output logic                   res_valid_o,
  output tjb_res_t               res_o
);

  localparam int unsigned PtrW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

  // Controller states.
  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_INS_CMP = 3'd1;
  localparam logic [2:0] ST_INS_PUT = 3'd2;
  localparam logic [2:0] ST_EMIT    = 3'd3;
  localparam logic [2:0] ST_WAIT    = 3'd4;

  logic [2:0]      state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic [PtrW-1:0] head_q, head_d;
  logic [WinW-1:0] window_q;
  logic            pend_q, pend_d;
  logic            res_valid_q, res_valid_d;

  // Payload registers: the frame being inserted, the walk pointers, the
  // cached oldest and newest entries and the frame awaiting its result.
  logic [TimeW-1:0] ins_time_q, ins_time_d;
  logic [TagW-1:0]  ins_tag_q, ins_tag_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [CntW-1:0]  walk_q, walk_d;
  logic [TimeW-1:0] oldest_time_q, oldest_time_d;
  logic [TagW-1:0]  oldest_tag_q, oldest_tag_d;
  logic [TimeW-1:0] newest_time_q, newest_time_d;
  logic [TimeW-1:0] rel_time_q, rel_time_d;
  logic [TagW-1:0]  rel_tag_q, rel_tag_d;
  tjb_res_t         res_q, res_d;

  // Memory ports.
  logic            mem_we;
  logic [PtrW-1:0] mem_waddr;
  tjb_entry_t      mem_wdata;
  logic [PtrW-1:0] mem_raddr;
  tjb_entry_t      mem_rdata;

  tjb_slot_mem #(
    .DEPTH(DEPTH)
  ) u_slot_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    ptr_inc = (p == PtrLast) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [PtrW-1:0] ptr_dec(input logic [PtrW-1:0] p);
    ptr_dec = (p == '0) ? PtrLast : p - 1'b1;
  endfunction

  // Physical slot of the newest stored frame (valid when the store is not
  // empty). The sum stays below twice the depth, so one subtract wraps it.
  logic [PtrW:0]   tail_sum;
  logic [PtrW-1:0] tail_ptr;
  always_comb begin
    tail_sum = {1'b0, head_q} + (PtrW + 1)'(count_q) - 1'b1;
    if (tail_sum >= (PtrW + 1)'(DEPTH)) begin
      tail_sum = tail_sum - (PtrW + 1)'(DEPTH);
    end
    tail_ptr = tail_sum[PtrW-1:0];
  end

  // Spread of the store as it stands and the release test against it.
  logic [TimeW-1:0] spread_raw;
  logic [TimeW-1:0] spread_now;
  logic             store_nz;
  logic             release_ok;
  assign store_nz   = (count_q != '0);
  assign spread_raw = newest_time_q - oldest_time_q;
  assign spread_now = store_nz ? spread_raw : '0;
  assign release_ok = store_nz && (spread_raw >= TimeW'(window_q));

  logic accept;
  assign accept = start_i && (state_q == ST_IDLE);

  always_comb begin
    state_d       = state_q;
    count_d       = count_q;
    head_d        = head_q;
    pend_d        = pend_q;
    res_valid_d   = 1'b0;
    ins_time_d    = ins_time_q;
    ins_tag_d     = ins_tag_q;
    rd_ptr_d      = rd_ptr_q;
    wr_ptr_d      = wr_ptr_q;
    walk_d        = walk_q;
    oldest_time_d = oldest_time_q;
    oldest_tag_d  = oldest_tag_q;
    newest_time_d = newest_time_q;
    rel_time_d    = rel_time_q;
    rel_tag_d     = rel_tag_q;
    res_d         = res_q;
    mem_we        = 1'b0;
    mem_waddr     = wr_ptr_q;
    mem_wdata     = '{slot_time: ins_time_q, slot_tag: ins_tag_q};
    mem_raddr     = rd_ptr_q;

    case (state_q)
      ST_IDLE: begin
        mem_raddr = tail_ptr;
        if (accept) begin
          // Single-result items are answered from the current state.
          res_d = '{has_frame: 1'b0, out_tag: '0, out_time: '0, accepted: 1'b0,
                    pending: PendW'(count_q), spread: spread_now, last: 1'b1};
          if (in_i.kind == KIND_CLEAR) begin
            count_d       = '0;
            res_d.accepted = 1'b1;
            res_d.pending  = '0;
            res_d.spread   = '0;
            res_valid_d    = 1'b1;
          end else if (in_i.kind != KIND_MEDIA) begin
            res_valid_d = 1'b1;
          end else if (window_q == '0) begin
            res_d.has_frame = 1'b1;
            res_d.out_tag   = in_i.frame_tag;
            res_d.out_time  = in_i.frame_time;
            res_d.accepted  = 1'b1;
            res_valid_d     = 1'b1;
          end else if (count_q == CntFull) begin
            res_valid_d = 1'b1;
          end else begin
            ins_time_d = in_i.frame_time;
            ins_tag_d  = in_i.frame_tag;
            pend_d     = 1'b0;
            if (!store_nz) begin
              // Empty store: the frame becomes both ends at the head slot.
              mem_we        = 1'b1;
              mem_waddr     = head_q;
              mem_wdata     = '{slot_time: in_i.frame_time, slot_tag: in_i.frame_tag};
              count_d       = count_q + 1'b1;
              oldest_time_d = in_i.frame_time;
              oldest_tag_d  = in_i.frame_tag;
              newest_time_d = in_i.frame_time;
              state_d       = ST_EMIT;
            end else begin
              // Start the walk at the newest entry; the read is in flight now.
              rd_ptr_d = tail_ptr;
              wr_ptr_d = ptr_inc(tail_ptr);
              walk_d   = count_q - 1'b1;
              if (in_i.frame_time >= newest_time_q) begin
                newest_time_d = in_i.frame_time;
              end
              state_d = ST_INS_CMP;
            end
          end
        end
      end

      ST_INS_CMP: begin
        mem_we    = 1'b1;
        mem_waddr = wr_ptr_q;
        mem_raddr = ptr_dec(rd_ptr_q);
        if (mem_rdata.slot_time > ins_time_q) begin
          // Entry is newer: move it up one slot and look at the next older.
          mem_wdata = mem_rdata;
          wr_ptr_d  = rd_ptr_q;
          rd_ptr_d  = ptr_dec(rd_ptr_q);
          walk_d    = walk_q - 1'b1;
          if (walk_q == '0) begin
            state_d = ST_INS_PUT;
          end
        end else begin
          // Equal or older entry found: the new frame goes right after it.
          count_d = count_q + 1'b1;
          state_d = ST_EMIT;
        end
      end

      ST_INS_PUT: begin
        // The frame is older than everything stored and takes the head slot.
        mem_we        = 1'b1;
        mem_waddr     = wr_ptr_q;
        count_d       = count_q + 1'b1;
        oldest_time_d = ins_time_q;
        oldest_tag_d  = ins_tag_q;
        state_d       = ST_EMIT;
      end

      ST_EMIT: begin
        // Report the frame released before (if any), then decide whether
        // the oldest entry goes out as well. A result with no frame is sent
        // only when nothing at all is released.
        mem_raddr = ptr_inc(head_q);
        if (pend_q) begin
          res_d = '{has_frame: 1'b1, out_tag: rel_tag_q, out_time: rel_time_q,
                    accepted: 1'b1, pending: PendW'(count_q), spread: spread_now,
                    last: !release_ok};
          res_valid_d = 1'b1;
        end else if (!release_ok) begin
          res_d = '{has_frame: 1'b0, out_tag: '0, out_time: '0, accepted: 1'b1,
                    pending: PendW'(count_q), spread: spread_now, last: 1'b1};
          res_valid_d = 1'b1;
        end
        if (release_ok) begin
          rel_time_d = oldest_time_q;
          rel_tag_d  = oldest_tag_q;
          count_d    = count_q - 1'b1;
          head_d     = ptr_inc(head_q);
          pend_d     = 1'b1;
          state_d    = ST_WAIT;
        end else begin
          pend_d  = 1'b0;
          state_d = ST_IDLE;
        end
      end

      ST_WAIT: begin
        // The new head entry arrives from memory.
        oldest_time_d = mem_rdata.slot_time;
        oldest_tag_d  = mem_rdata.slot_tag;
        state_d       = ST_EMIT;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      head_q      <= '0;
      pend_q      <= 1'b0;
      res_valid_q <= 1'b0;
      window_q    <= '0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      head_q      <= head_d;
      pend_q      <= pend_d;
      res_valid_q <= res_valid_d;
      if (cfg_we_i) begin
        window_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ins_time_q    <= ins_time_d;
    ins_tag_q     <= ins_tag_d;
    rd_ptr_q      <= rd_ptr_d;
    wr_ptr_q      <= wr_ptr_d;
    walk_q        <= walk_d;
    oldest_time_q <= oldest_time_d;
    oldest_tag_q  <= oldest_tag_d;
    newest_time_q <= newest_time_d;
    rel_time_q    <= rel_time_d;
    rel_tag_q     <= rel_tag_d;
    res_q         <= res_d;
  end

  assign busy_o      = (state_q != ST_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule : timestamp_jitter_buffer_unit
`default_nettype wire

>>> sim/tjb_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Jitter buffer result checker
// Follows every transfer and window write into the jitter buffer, works out
// the results from its own copy of the sorted store, and compares each
// result strobe, field by field, with the oldest result still owed.
// ----------------------------------------------------------------------------
module tjb_checker
  import tjb_pkg::*;
#(
  parameter int unsigned Depth = DepthDefault
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic            busy_i,
  input  tjb_in_t         in_i,
  input  logic            cfg_we_i,
  input  logic [WinW-1:0] cfg_wdata_i,
  input  logic            res_valid_i,
  input  tjb_res_t        res_i,
  output int unsigned     fail_count_o,
  output int unsigned     owed_count_o,
  output int unsigned     checked_count_o,
  output int unsigned     released_count_o
);

  // Only the first few failures are printed; all of them are counted.
  localparam int unsigned ReportCap = 30;

  logic [TimeW-1:0] shadow_time [Depth];
  logic [TagW-1:0]  shadow_tag  [Depth];
  int unsigned      shadow_fill = 0;
  logic [WinW-1:0]  window_q    = '0;
  tjb_res_t         owed_results [$];

  function automatic logic [TimeW-1:0] shadow_spread();
    if (shadow_fill == 0) return '0;
    return shadow_time[shadow_fill-1] - shadow_time[0];
  endfunction

  function automatic bit release_due();
    return (shadow_fill > 0) && (shadow_spread() >= window_q);
  endfunction

  task automatic owe(input logic has, input logic [TagW-1:0] tag,
                     input logic [TimeW-1:0] stamp, input logic acc, input logic fin);
    tjb_res_t r;
    r.has_frame = has;
    r.out_tag   = tag;
    r.out_time  = stamp;
    r.accepted  = acc;
    r.pending   = PendW'(shadow_fill);
    r.spread    = shadow_spread();
    r.last      = fin;
    owed_results.push_back(r);
  endtask

  task automatic predict_results(input tjb_in_t item);
    int unsigned      pos;
    bit               released;
    logic [TimeW-1:0] rel_time;
    logic [TagW-1:0]  rel_tag;
    case (item.kind)
      KIND_MEDIA: begin
        if (window_q == '0) begin
          // Transit mode: the frame goes straight out, the store is left alone.
          owe(1'b1, item.frame_tag, item.frame_time, 1'b1, 1'b1);
        end else if (shadow_fill >= Depth) begin
          owe(1'b0, '0, '0, 1'b0, 1'b1);
        end else begin
          // Stable insert: the new frame goes behind every equal timestamp.
          pos = shadow_fill;
          while (pos > 0 && shadow_time[pos-1] > item.frame_time) begin
            shadow_time[pos] = shadow_time[pos-1];
            shadow_tag[pos]  = shadow_tag[pos-1];
            pos--;
          end
          shadow_time[pos] = item.frame_time;
          shadow_tag[pos]  = item.frame_tag;
          shadow_fill++;
          released = 1'b0;
          while (release_due()) begin
            rel_time = shadow_time[0];
            rel_tag  = shadow_tag[0];
            for (int i = 1; i < shadow_fill; i++) begin
              shadow_time[i-1] = shadow_time[i];
              shadow_tag[i-1]  = shadow_tag[i];
            end
            shadow_fill--;
            released = 1'b1;
            owe(1'b1, rel_tag, rel_time, 1'b1, !release_due());
          end
          if (!released) owe(1'b0, '0, '0, 1'b1, 1'b1);
        end
      end
      KIND_CLEAR: begin
        shadow_fill = 0;
        owe(1'b0, '0, '0, 1'b1, 1'b1);
      end
      default: begin
        owe(1'b0, '0, '0, 1'b0, 1'b1);
      end
    endcase
  endtask

  task automatic compare_field(input string field, input logic [63:0] want,
                               input logic [63:0] got);
    if (got !== want) begin
      fail_count_o++;
      if (fail_count_o <= ReportCap)
        $error("%s mismatch: expected %0h, actual %0h", field, want, got);
    end
  endtask

  task automatic check_result(input tjb_res_t got);
    tjb_res_t want;
    if (owed_results.size() == 0) begin
      fail_count_o++;
      if (fail_count_o <= ReportCap)
        $error("result strobe with nothing owed: out_tag %0h, out_time %0h",
               got.out_tag, got.out_time);
    end else begin
      want = owed_results.pop_front();
      compare_field("has_frame", 64'(want.has_frame), 64'(got.has_frame));
      compare_field("out_tag",   64'(want.out_tag),   64'(got.out_tag));
      compare_field("out_time",  64'(want.out_time),  64'(got.out_time));
      compare_field("accepted",  64'(want.accepted),  64'(got.accepted));
      compare_field("pending",   64'(want.pending),   64'(got.pending));
      compare_field("spread",    64'(want.spread),    64'(got.spread));
      compare_field("last",      64'(want.last),      64'(got.last));
      checked_count_o++;
      if (want.has_frame) released_count_o++;
    end
  endtask

  // Results are checked before the transfer of the same edge is predicted,
  // since a result can never belong to an item taken in at that edge.
  // The counters are cleared at the edges seen while reset is held.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shadow_fill = 0;
      window_q    = '0;
      owed_results.delete();
      owed_count_o     = 0;
      fail_count_o     = 0;
      checked_count_o  = 0;
      released_count_o = 0;
    end else begin
      if (res_valid_i === 1'b1) check_result(res_i);
      if (cfg_we_i === 1'b1) window_q = cfg_wdata_i;
      if (start_i === 1'b1 && busy_i === 1'b0) predict_results(in_i);
      owed_count_o = owed_results.size();
    end
  end

endmodule : tjb_checker

>>> sim/tb_timestamp_jitter_buffer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timestamp jitter buffer testbench
// Drives directed and random items and window settings into the jitter
// buffer with random gaps; a checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_timestamp_jitter_buffer_unit;
  import tjb_pkg::*;

  localparam int unsigned Depth        = DepthDefault;
  // Kinds the block must refuse; the package names only the two it takes.
  localparam logic [1:0]  KindOther    = 2'd2;
  localparam logic [1:0]  KindSpare    = 2'd3;
  // Drain timeout, far longer than a full-store mass release runs.
  localparam int unsigned DrainLimit   = 20000;
  // Quiet cycles after the last owed result before the window is touched.
  localparam int unsigned SettleCycles = 8;

  // All block inputs start at known values and are driven only by
  // nonblocking assignments at rising edges afterwards.
  logic            clk       = 1'b0;
  logic            rst_n     = 1'b0;
  logic            start     = 1'b0;
  tjb_in_t         in_item   = '0;
  logic            cfg_we    = 1'b0;
  logic [WinW-1:0] cfg_wdata = '0;
  logic            busy;
  logic            res_valid;
  tjb_res_t        res;

  int unsigned fail_count;
  int unsigned owed_count;
  int unsigned checked_count;
  int unsigned released_count;

  int unsigned      items_sent    = 0;
  int unsigned      window_writes = 0;
  int unsigned      no_gap_left   = 0;
  bit               drain_stuck   = 1'b0;
  logic [TimeW-1:0] stamp_base    = '0;

  always #1 clk = ~clk;

  timestamp_jitter_buffer_unit #(
    .DEPTH(Depth)
  ) u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .start_i    (start),
    .busy_o     (busy),
    .in_i       (in_item),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  tjb_checker #(
    .Depth(Depth)
  ) u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .start_i         (start),
    .busy_i          (busy),
    .in_i            (in_item),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .res_valid_i     (res_valid),
    .res_i           (res),
    .fail_count_o    (fail_count),
    .owed_count_o    (owed_count),
    .checked_count_o (checked_count),
    .released_count_o(released_count)
  );

  // Random hold-off before the next transfer. Most gaps are zero or short,
  // a few are long, and now and then a burst of back-to-back items follows.
  // The gap starts right after the previous transfer, so it lands on
  // whatever the block is doing at that point: sorting, releasing or idle.
  task automatic pause_random();
    int unsigned roll;
    int unsigned n;
    roll = $urandom_range(0, 99);
    if (no_gap_left != 0) begin
      no_gap_left--;
      n = 0;
    end else if (roll < 5) begin
      no_gap_left = $urandom_range(5, 20);
      n = 0;
    end else if (roll < 55) begin
      n = 0;
    end else if (roll < 82) begin
      n = $urandom_range(1, 3);
    end else if (roll < 97) begin
      n = $urandom_range(4, 12);
    end else begin
      n = $urandom_range(30, 80);
    end
    if (n != 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // One transfer. start is raised with the item and stays high until the
  // edge that takes it; busy is looked at on the falling edge, where it is
  // settled, so the transfer happens at the next rising edge. start is left
  // high afterwards, so a follow-up item with no gap never sees it dip.
  task automatic send_item(input tjb_in_t it);
    pause_random();
    start   <= 1'b1;
    in_item <= it;
    do @(negedge clk); while (busy !== 1'b0);
    @(posedge clk);
    items_sent++;
  endtask

  task automatic send_fields(input logic [1:0] kind, input logic [TimeW-1:0] stamp,
                             input logic [TagW-1:0] tag);
    tjb_in_t it;
    it.kind       = kind;
    it.frame_time = stamp;
    it.frame_tag  = tag;
    send_item(it);
  endtask

  // Lowers start and waits until the checker owes nothing and the block
  // reports idle, then lets a few more cycles pass so that a stray result
  // would still be caught before the window is rewritten.
  task automatic drain_block();
    int unsigned waited;
    start <= 1'b0;
    waited = 0;
    @(negedge clk);
    while ((owed_count != 0 || busy !== 1'b0) && waited < DrainLimit) begin
      @(negedge clk);
      waited++;
    end
    if (waited >= DrainLimit) begin
      drain_stuck = 1'b1;
      $error("block did not drain: %0d results still owed", owed_count);
    end
    repeat (SettleCycles) @(posedge clk);
  endtask

  // Window writes are only issued from an idle block, after drain_block.
  task automatic set_window(input logic [WinW-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    window_writes++;
  endtask

  // Random item for the mixed phases. Timestamps follow a rising base with
  // jitter scaled to the window, so frames really get reordered and
  // released; a few take fully random timestamps to reach the high bits.
  // Clears and refused kinds are mixed in as noise.
  task automatic next_item(input logic [WinW-1:0] win, output tjb_in_t it);
    int unsigned roll;
    int unsigned step_max;
    int unsigned jitter;
    roll       = $urandom_range(0, 99);
    step_max   = (win >> 3) + 40;
    stamp_base = stamp_base + $urandom_range(0, step_max);
    jitter     = $urandom_range(0, 2 * step_max);
    it.frame_tag  = TagW'($urandom);
    it.frame_time = (stamp_base > jitter) ? stamp_base - jitter : stamp_base;
    if (roll < 3) it.frame_time = TimeW'({$urandom, $urandom});
    if (roll < 85)      it.kind = KIND_MEDIA;
    else if (roll < 91) it.kind = KIND_CLEAR;
    else if (roll < 96) it.kind = KindOther;
    else                it.kind = KindSpare;
  endtask

  task automatic run_phase(input logic [WinW-1:0] win, input int unsigned count);
    tjb_in_t it;
    set_window(win);
    repeat (count) begin
      next_item(win, it);
      send_item(it);
    end
    drain_block();
  endtask

  initial begin
    logic [TimeW-1:0] big;
    logic [WinW-1:0]  win_now;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- Directed part ------------------------------------------------------
    // Window is zero after reset: transit mode with extreme fields, the
    // refused kinds and a clear of the empty store.
    send_fields(KIND_MEDIA, '1, '1);
    send_fields(KIND_MEDIA, '0, '0);
    send_fields(KindOther, TimeW'(77), TagW'(16'h1234));
    send_fields(KindSpare, '1, '1);
    send_fields(KIND_CLEAR, '0, '0);
    drain_block();

    // Window of 100: inserts that free nothing, equal timestamps, a frame in
    // front of all, a refused kind with frames stored, then a single and a
    // multiple release, and a clear of a non-empty store.
    set_window(32'd100);
    send_fields(KIND_MEDIA, TimeW'(1000), TagW'(1));
    send_fields(KIND_MEDIA, TimeW'(1000), TagW'(2));
    send_fields(KIND_MEDIA, TimeW'(990),  TagW'(3));
    send_fields(KIND_MEDIA, TimeW'(1050), TagW'(4));
    send_fields(KIND_MEDIA, TimeW'(1020), TagW'(5));
    send_fields(KindOther,  TimeW'(1),    TagW'(6));
    send_fields(KIND_MEDIA, TimeW'(1095), TagW'(7));
    send_fields(KIND_MEDIA, TimeW'(1200), TagW'(8));
    send_fields(KIND_CLEAR, '0, '0);
    send_fields(KIND_MEDIA, TimeW'(500),  TagW'(9));
    send_fields(KIND_MEDIA, TimeW'(520),  TagW'(10));
    drain_block();

    // Back to transit mode with two frames still stored: they must stay
    // untouched and show up in pending and spread.
    set_window(32'd0);
    send_fields(KIND_MEDIA, TimeW'(12345), TagW'(16'hABCD));
    drain_block();

    // Widest window: only a huge timestamp gap releases anything.
    set_window('1);
    send_fields(KIND_MEDIA, '0, TagW'(11));
    send_fields(KIND_MEDIA, '1, '1);
    send_fields(KIND_CLEAR, '0, '0);
    drain_block();

    // Narrowest window: equal stamps wait, the next tick frees both in order.
    set_window(32'd1);
    send_fields(KIND_MEDIA, TimeW'(5), TagW'(12));
    send_fields(KIND_MEDIA, TimeW'(5), TagW'(13));
    send_fields(KIND_MEDIA, TimeW'(6), TagW'(14));
    drain_block();

    // ---- Random part --------------------------------------------------------
    stamp_base = TimeW'(1_000_000);
    run_phase(32'd0, 13);
    run_phase(32'd1, 15);

    // Deep fill: with the widest window, Depth - 1 frames with small random
    // stamps are sent to fill the store.
    set_window('1);
    repeat (Depth - 1) send_fields(KIND_MEDIA, TimeW'($urandom_range(0, 1 << 20)),
                                   TagW'($urandom));
    drain_block();

    // Window lowered under a nearly full store: nothing leaves until the
    // next frame, whose far-off stamp then flushes almost the whole store.
    win_now = $urandom_range(1, 1000);
    set_window(win_now);
    big = (TimeW'(1) << 40) + $urandom_range(0, 1000);
    send_fields(KIND_MEDIA, big, TagW'($urandom));
    stamp_base = big;
    repeat (4) begin
      tjb_in_t it;
      next_item(win_now, it);
      send_item(it);
    end
    drain_block();

    // Full store: more frames than slots, so the tail is refused, and a
    // refused kind against the full store.
    set_window('1);
    repeat (Depth + 6) send_fields(KIND_MEDIA, stamp_base + $urandom_range(0, 5000),
                                   TagW'($urandom));
    send_fields(KindOther, TimeW'($urandom), TagW'($urandom));
    drain_block();

    // Mixed phases over wide, narrow and medium windows, then transit again
    // with whatever the store still holds.
    run_phase($urandom, 15);
    run_phase($urandom_range(2, 300), 15);
    run_phase($urandom_range(2, 5000), 15);
    run_phase(32'd0, 15);

    // Read the checker's counters away from the rising edge it updates on.
    @(negedge clk);
    $display("Sent %0d items over %0d window settings (transit, full store, mass release).",
             items_sent, window_writes);
    $display("Checked %0d results, %0d of them carrying released frames.",
             checked_count, released_count);
    if (fail_count == 0 && !drain_stuck) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog: the slowest legal run is well under a fifth of this.
  initial begin
    #1_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule : tb_timestamp_jitter_buffer_unit

>>> sim.f
hw/rtl/tjb_pkg.sv
hw/rtl/tjb_slot_mem.sv
hw/rtl/timestamp_jitter_buffer_unit.sv
sim/tjb_checker.sv
sim/tb_timestamp_jitter_buffer_unit.sv
